// ----- rtl/core/ida_pkg.sv -----
package ida_pkg;

  localparam int ValueWidth  = 64;
  localparam int NumDigits   = 20;
  localparam int DigitIdxW   = $clog2(NumDigits);
  localparam int BitsPerStep = 4;
  localparam int ConvSteps   = ValueWidth / BitsPerStep;
  localparam int StepCntW    = $clog2(ConvSteps);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_MEAS,
    ST_SIGN,
    ST_DIGIT
  } ida_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic convert;
    logic measure;
    logic emit_sign;
    logic emit_digit;
  } ida_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic conv_done;  // last conversion step in progress
    logic neg;
    logic idx_zero;   // current digit is the final one
    logic out_free;   // output register can take a beat this cycle
  } ida_sts_t;

endpackage

// ----- rtl/core/ida_datapath.sv -----
module ida_datapath
  import ida_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ida_cmd_t              cmd,
  output ida_sts_t              sts,
  input  logic [ValueWidth-1:0] in_value,
  input  logic                  in_signed,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [7:0]            out_byte,
  output logic                  out_last
);

  logic [ValueWidth-1:0]  mag;
  logic [ValueWidth-1:0]  mag_next;
  logic [NumDigits*4-1:0] bcd;
  logic [NumDigits*4-1:0] bcd_next;
  logic [StepCntW-1:0]    step_cnt;
  logic [DigitIdxW-1:0]   idx;
  logic [DigitIdxW-1:0]   lead_idx;
  logic                   neg;
  logic                   in_neg;
  logic [3:0]             cur_digit;

  assign in_neg = in_signed & in_value[ValueWidth-1];

  // Double dabble, BitsPerStep bits per cycle.
  always_comb begin
    logic [NumDigits*4-1:0] b;
    logic [ValueWidth-1:0]  m;
    b = bcd;
    m = mag;
    for (int s = 0; s < BitsPerStep; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (b[d*4 +: 4] >= 4'd5) begin
          b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
        end
      end
      b = {b[NumDigits*4-2:0], m[ValueWidth-1]};
      m = {m[ValueWidth-2:0], 1'b0};
    end
    bcd_next = b;
    mag_next = m;
  end

  // Highest nonzero digit; zero when the value is zero.
  always_comb begin
    lead_idx = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (bcd[d*4 +: 4] != 4'd0) begin
        lead_idx = DigitIdxW'(d);
      end
    end
  end

  assign cur_digit = bcd[idx*4 +: 4];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= in_neg ? (~in_value + ValueWidth'(1)) : in_value;
      bcd <= '0;
      neg <= in_neg;
    end else if (cmd.convert) begin
      mag <= mag_next;
      bcd <= bcd_next;
    end
    if (cmd.measure) begin
      idx <= lead_idx;
    end else if (cmd.emit_digit) begin
      idx <= idx - DigitIdxW'(1);
    end
    if (cmd.emit_sign) begin
      out_byte <= CHAR_MINUS;
      out_last <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_byte <= CHAR_ZERO | {4'd0, cur_digit};
      out_last <= (idx == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        step_cnt <= '0;
      end else if (cmd.convert) begin
        step_cnt <= step_cnt + StepCntW'(1);
      end
      if (cmd.emit_sign || cmd.emit_digit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.conv_done = (step_cnt == StepCntW'(ConvSteps - 1));
  assign sts.neg       = neg;
  assign sts.idx_zero  = (idx == '0);
  assign sts.out_free  = ~out_valid | out_ready;

endmodule

// ----- rtl/core/ida_ctrl.sv -----
module ida_ctrl
  import ida_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ida_sts_t sts,
  output ida_cmd_t cmd
);

  ida_state_t state;
  ida_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_CONV;
      ST_CONV:  if (sts.conv_done) state_next = ST_MEAS;
      ST_MEAS:  state_next = sts.neg ? ST_SIGN : ST_DIGIT;
      ST_SIGN:  if (sts.out_free) state_next = ST_DIGIT;
      ST_DIGIT: if (sts.out_free && sts.idx_zero) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV:  cmd.convert    = 1'b1;
      ST_MEAS:  cmd.measure    = 1'b1;
      ST_SIGN:  cmd.emit_sign  = sts.out_free;
      ST_DIGIT: cmd.emit_digit = sts.out_free;
      default: ;
    endcase
  end

  a_conv_to_meas: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV && sts.conv_done) |=> (state == ST_MEAS))
    else $error("conversion did not hand over to digit count");

  a_sign_only_neg: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIGN) |-> sts.neg)
    else $error("sign state entered for a non-negative value");

  a_last_digit_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_digit && sts.idx_zero) |=> (state == ST_IDLE))
    else $error("final digit did not end the item");

endmodule

// ----- rtl/core/integer_to_decimal_ascii.sv -----
// 64-bit integer to decimal ASCII text.
//
// Input channel (s_*): one beat carries a 64-bit word in s_tdata and in
// s_tuser a flag that reads the word as two's complement (1) or unsigned (0).
// Output channel (m_*): one ASCII character per beat in m_tdata, most
// significant digit first, with a leading '-' for negative signed values.
// m_tlast marks the final character. Zero gives a single '0'.
//
// Timing: after an input beat is taken, double dabble (four bits per cycle)
// builds the BCD digits, a measure state finds the leading digit, then one
// character a cycle is emitted while m_tready stays high. s_tready is high
// only between items, so a new word is taken only after the final character
// of the previous item has been written to the output register.
//
// Reset (rst, synchronous) drops m_tvalid and returns to idle. A stall on
// m_tready holds the registered character; the sequencer waits until the
// output register drains before writing the next character.
module integer_to_decimal_ascii
  import ida_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] value
  input  logic [0:0]  s_tuser,   // [0] is_signed
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] char_byte
  output logic        m_tlast
);

  ida_cmd_t cmd;
  ida_sts_t sts;

  // sequencer
  ida_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // BCD conversion and output register
  ida_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_value  (s_tdata),
    .in_signed (s_tuser[0]),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
